// ----- sv/lztp_pkg.sv -----
`default_nettype none
package lztp_pkg;

    localparam int CHUNK_MAX_DEF = 65536;
    localparam int SYMBOL_BINS   = 512;
    localparam int GROUP_TOKENS  = 32;
    localparam int HIST_ROWS     = SYMBOL_BINS / 2;
    localparam int TOK_BYTES     = 6;

    localparam logic [1:0] ACT_LITERAL = 2'd0;
    localparam logic [1:0] ACT_MATCH   = 2'd1;
    localparam logic [1:0] ACT_READ    = 2'd2;
    localparam logic [1:0] ACT_NONE    = 2'd3;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_COUNT = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic CFG_CHUNK_LENGTH = 1'b0;
    localparam logic CFG_FINAL_CHUNK  = 1'b1;

    localparam logic [8:0]  EOS_BIN   = 9'h100;
    localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  literal_byte;
        logic [16:0] match_length;
        logic [15:0] match_offset;
        logic [8:0]  bin_index;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  byte_value;
        logic [16:0] byte_address;
        logic [16:0] bin_count;
        logic        chunk_done;
        logic [16:0] buffer_length;
        logic        last;
    } out_word_t;

    typedef struct packed {
        logic [2:0]      nbytes;
        logic [5:0][7:0] bytes;
        logic [8:0]      bin;
    } tok_t;

    typedef struct packed {
        logic [8:0] rd_bin;
        logic       clear;
        logic       bump;
    } hist_ctl_t;

    typedef enum logic [3:0] {
        S_IDLE, S_HREAD, S_ERR, S_BUMP, S_TOK, S_MASK, S_NEWM, S_END, S_EOS
    } state_t;

endpackage
`default_nettype wire

// ----- sv/lz77_token_packer_with_histogram.sv -----
`default_nettype none
// A token taken in S_IDLE bumps its bin in S_BUMP, then registers its bytes from S_TOK;
// an error or a bin read loads its one word from S_ERR or S_HREAD.
// Throughput: one output word a cycle unless out_stall holds it; the input stalls for a
// token's run: read-modify-write in the 512-bin histogram, its words, any EOS count bump.
// Reset: no chunk open, addresses and mask zero, chunk_length 65536, final_chunk 1,
// all histogram rows marked empty at once.
module lz77_token_packer_with_histogram
    import lztp_pkg::*;
#(
    parameter int CHUNK_MAX = CHUNK_MAX_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [16:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire in_word_t    in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output out_word_t        out_data
);
    // config
    logic [16:0] chunk_len_reg;
    logic        final_reg;

    // packer state
    logic [16:0] bytes_left_reg, bytes_left_next;
    logic [16:0] wa_reg, wa_next;
    logic [16:0] ma_reg, ma_next;
    logic [31:0] mask_reg, mask_next;
    logic [5:0]  slot_reg, slot_next;

    // run registers: what the current word sequence emits
    state_t          state_reg, state_next;
    logic [5:0][7:0] tb_reg, tb_next;
    logic [2:0]      n_reg, n_next;
    logic [2:0]      idx_reg, idx_next;
    logic [16:0]     ea_reg, ea_next;
    logic [16:0]     mbase_reg, mbase_next;
    logic [31:0]     mval_reg, mval_next;
    logic            dmask_reg, dmask_next;
    logic            dnew_reg, dnew_next;
    logic            dend_reg, dend_next;
    logic            done_reg, done_next;
    logic [16:0]     blen_reg, blen_next;
    logic [8:0]      hbin_reg, hbin_next;

    // output register
    logic      ov_reg, ov_next;
    out_word_t ow_reg, ow_next;

    logic      accept, can_load;
    hist_ctl_t hctl;
    logic [16:0] hcount;
    tok_t        tok;

    // accept-time decode
    logic        start, is_match, err, full, endc;
    logic [16:0] eff, avail, len, bl1, wa0, wa1, wa2, wa3, wa4, ma0;
    logic [31:0] mask0, mask1, mask_close;
    logic [5:0]  slot0, slot1;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign can_load  = !ov_reg || !out_stall;
    assign out_valid = ov_reg;
    assign out_data  = ow_reg;

    lztp_enc u_enc (
        .is_match     (is_match),
        .literal_byte (in_data.literal_byte),
        .len          (len),
        .offset       (in_data.match_offset),
        .tok          (tok)
    );

    lztp_hist u_hist (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (hctl),
        .count (hcount)
    );

    always_comb
    begin
        start    = (bytes_left_reg == 17'd0);
        eff      = (chunk_len_reg == 17'd0) ? 17'd1 :
                   ({15'd0, chunk_len_reg} > CHUNK_MAX) ? 17'(CHUNK_MAX) : chunk_len_reg;
        avail    = start ? eff : bytes_left_reg;
        is_match = (in_data.action == ACT_MATCH);
        err      = is_match && ((in_data.match_length < 17'd3) || (avail < 17'd3));
        len      = !is_match ? 17'd1 :
                   (in_data.match_length < avail) ? in_data.match_length : avail;
        bl1      = avail - len;
        endc     = (bl1 == 17'd0);
        wa0      = start ? 17'd4 : wa_reg;
        ma0      = start ? 17'd0 : ma_reg;
        mask0    = start ? 32'd0 : mask_reg;
        slot0    = start ? 6'd0 : slot_reg;
        wa1      = wa0 + {14'd0, tok.nbytes};
        mask1    = mask0 | (is_match ? (32'd1 << slot0[4:0]) : 32'd0);
        slot1    = slot0 + 6'd1;
        full     = slot1[5];
        // end-of-stream flag takes the next slot of an open group
        mask_close = full ? mask1 :
                     (mask1 | ((endc && final_reg) ? (32'd1 << slot1[4:0]) : 32'd0));
        wa2      = (full && !endc) ? wa1 + 17'd4 : wa1;
        wa3      = (full && endc && final_reg) ? wa2 + 17'd4 : wa2;
        wa4      = (endc && final_reg) ? wa3 + 17'd3 : wa3;
    end

    // histogram port: bin of the incoming word, the held read bin, else end-of-stream
    always_comb
    begin
        hctl = '0;
        unique case (state_reg)
            S_IDLE:  hctl.rd_bin = (in_data.action == ACT_READ) ? in_data.bin_index : tok.bin;
            S_HREAD: hctl.rd_bin = hbin_reg;
            default: hctl.rd_bin = EOS_BIN;
        endcase
        hctl.clear = accept && start && !err &&
                     ((in_data.action == ACT_LITERAL) || (in_data.action == ACT_MATCH));
        hctl.bump  = (state_reg == S_BUMP) || (state_reg == S_EOS);
    end

    always_comb
    begin
        state_next      = state_reg;
        bytes_left_next = bytes_left_reg;
        wa_next         = wa_reg;
        ma_next         = ma_reg;
        mask_next       = mask_reg;
        slot_next       = slot_reg;
        tb_next         = tb_reg;
        n_next          = n_reg;
        idx_next        = idx_reg;
        ea_next         = ea_reg;
        mbase_next      = mbase_reg;
        mval_next       = mval_reg;
        dmask_next      = dmask_reg;
        dnew_next       = dnew_reg;
        dend_next       = dend_reg;
        done_next       = done_reg;
        blen_next       = blen_reg;
        hbin_next       = hbin_reg;
        ov_next         = ov_reg && out_stall;
        ow_next         = ow_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_data.action)
                        ACT_READ:
                        begin
                            hbin_next  = in_data.bin_index;
                            state_next = S_HREAD;
                        end
                        ACT_LITERAL, ACT_MATCH:
                        begin
                            if (err)
                            begin
                                state_next = S_ERR;
                            end
                            else
                            begin
                                bytes_left_next = bl1;
                                wa_next    = wa4;
                                ma_next    = (full && !endc) ? wa1 : ma0;
                                mask_next  = (full && !endc) ? 32'd0 : mask_close;
                                slot_next  = (full && !endc) ? 6'd0 : slot1;
                                tb_next    = tok.bytes;
                                n_next     = tok.nbytes;
                                idx_next   = 3'd0;
                                ea_next    = wa0;
                                mbase_next = ma0;
                                mval_next  = mask_close;
                                dmask_next = full || endc;
                                dnew_next  = full && endc && final_reg;
                                dend_next  = endc && final_reg;
                                done_next  = endc;
                                blen_next  = endc ? wa4 : 17'd0;
                                state_next = S_BUMP;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_HREAD:
            begin
                if (can_load)
                begin
                    ov_next           = 1'b1;
                    ow_next           = '0;
                    ow_next.kind      = KIND_COUNT;
                    ow_next.bin_count = hcount;
                    ow_next.last      = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            S_ERR:
            begin
                if (can_load)
                begin
                    ov_next      = 1'b1;
                    ow_next      = '0;
                    ow_next.kind = KIND_ERROR;
                    ow_next.last = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_BUMP:
            begin
                state_next = S_TOK;
            end
            S_TOK, S_MASK, S_NEWM, S_END:
            begin
                if (can_load)
                begin
                    ov_next               = 1'b1;
                    ow_next               = '0;
                    ow_next.kind          = KIND_BYTE;
                    ow_next.chunk_done    = done_reg;
                    ow_next.buffer_length = blen_reg;
                    idx_next              = idx_reg + 3'd1;
                    ea_next               = ea_reg + 17'd1;
                    ow_next.byte_address  = ea_reg;
                    if (state_reg == S_TOK)
                    begin
                        ow_next.byte_value = tb_reg[idx_reg];
                        if (idx_reg == n_reg - 3'd1)
                        begin
                            idx_next     = 3'd0;
                            ow_next.last = !dmask_reg && !dnew_reg && !dend_reg;
                            state_next   = dmask_reg ? S_MASK : dnew_reg ? S_NEWM :
                                           dend_reg ? S_END : S_IDLE;
                        end
                    end
                    else if (state_reg == S_MASK)
                    begin
                        // mask bytes sit at the reserved slot, little-endian
                        ea_next              = ea_reg;
                        ow_next.byte_address = mbase_reg + {15'd0, idx_reg[1:0]};
                        ow_next.byte_value   = mval_reg[8*idx_reg[1:0] +: 8];
                        if (idx_reg[1:0] == 2'd3)
                        begin
                            idx_next     = 3'd0;
                            ow_next.last = !dnew_reg && !dend_reg;
                            state_next   = dnew_reg ? S_NEWM : dend_reg ? S_END : S_IDLE;
                        end
                    end
                    else if (state_reg == S_NEWM)
                    begin
                        ow_next.byte_value = (idx_reg == 3'd0) ? 8'd1 : 8'd0;
                        if (idx_reg[1:0] == 2'd3)
                        begin
                            idx_next     = 3'd0;
                            ow_next.last = !dend_reg;
                            state_next   = dend_reg ? S_END : S_IDLE;
                        end
                    end
                    else
                    begin
                        ow_next.byte_value = 8'd0;
                        if (idx_reg == 3'd2)
                        begin
                            idx_next     = 3'd0;
                            ow_next.last = 1'b1;
                            state_next   = S_EOS;
                        end
                    end
                end
            end
            S_EOS:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            chunk_len_reg  <= 17'h10000;
            final_reg      <= 1'b1;
            bytes_left_reg <= '0;
            wa_reg         <= '0;
            ma_reg         <= '0;
            mask_reg       <= '0;
            slot_reg       <= '0;
            ov_reg         <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            bytes_left_reg <= bytes_left_next;
            wa_reg         <= wa_next;
            ma_reg         <= ma_next;
            mask_reg       <= mask_next;
            slot_reg       <= slot_next;
            ov_reg         <= ov_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_CHUNK_LENGTH: chunk_len_reg <= cfg_data;
                    CFG_FINAL_CHUNK:  final_reg     <= cfg_data[0];
                    default:          final_reg     <= final_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tb_reg    <= tb_next;
        n_reg     <= n_next;
        idx_reg   <= idx_next;
        ea_reg    <= ea_next;
        mbase_reg <= mbase_next;
        mval_reg  <= mval_next;
        dmask_reg <= dmask_next;
        dnew_reg  <= dnew_next;
        dend_reg  <= dend_next;
        done_reg  <= done_next;
        blen_reg  <= blen_next;
        hbin_reg  <= hbin_next;
        ow_reg    <= ow_next;
    end
endmodule
`default_nettype wire

// ----- sv/lztp_ram.sv -----
`default_nettype none
module lztp_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- sv/lztp_hist.sv -----
`default_nettype none
module lztp_hist
    import lztp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire hist_ctl_t   ctl,
    output logic [16:0]      count
);
    logic [HIST_ROWS-1:0] valid_reg, valid_next;
    logic [8:0]           bin_reg;
    logic [33:0]          rdata, wdata;
    logic [16:0]          lo, hi, inc;
    logic                 row_ok;

    lztp_ram #(.WIDTH(34), .DEPTH(HIST_ROWS)) u_ram (
        .clk   (clk),
        .we    (ctl.bump),
        .waddr (bin_reg[8:1]),
        .wdata (wdata),
        .raddr (ctl.rd_bin[8:1]),
        .rdata (rdata)
    );

    // a row not yet written this chunk reads as zero
    always_comb
    begin
        row_ok = valid_reg[bin_reg[8:1]];
        lo     = row_ok ? rdata[16:0]  : 17'd0;
        hi     = row_ok ? rdata[33:17] : 17'd0;
        count  = bin_reg[0] ? hi : lo;
        inc    = (count == COUNT_MAX) ? count : count + 17'd1;
        wdata  = bin_reg[0] ? {inc, lo} : {hi, inc};
        valid_next = valid_reg;
        if (ctl.clear)
        begin
            valid_next = '0;
        end
        else if (ctl.bump)
        begin
            valid_next[bin_reg[8:1]] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= ctl.rd_bin;
    end
endmodule
`default_nettype wire

// ----- sv/lztp_enc.sv -----
`default_nettype none
module lztp_enc
    import lztp_pkg::*;
(
    input  wire logic        is_match,
    input  wire logic [7:0]  literal_byte,
    input  wire logic [16:0] len,
    input  wire logic [15:0] offset,
    output tok_t             tok
);
    logic [15:0] t, off;
    logic [3:0]  bits;
    logic [16:0] l, lx;
    logic [3:0]  lnib;
    logic [7:0]  sym;

    always_comb
    begin
        t    = offset | 16'd1;
        bits = 4'd0;
        for (int i = 1; i < 16; i++)
        begin
            if (t[i])
            begin
                bits = 4'(i);
            end
        end
        off  = offset ^ (16'd1 << bits);
        l    = len - 17'd3;
        lnib = (l < 17'hF) ? l[3:0] : 4'hF;
        sym  = {bits, lnib};
        lx   = l - 17'hF;
        tok  = '0;
        if (!is_match)
        begin
            tok.nbytes   = 3'd1;
            tok.bytes[0] = literal_byte;
            tok.bin      = {1'b0, literal_byte};
        end
        else
        begin
            tok.bin      = {1'b1, sym};
            tok.bytes[0] = sym;
            tok.bytes[1] = off[7:0];
            tok.bytes[2] = off[15:8];
            // length escapes: one byte, or 0xFF then 16-bit length
            if (l >= 17'h10E)
            begin
                tok.nbytes   = 3'd6;
                tok.bytes[3] = 8'hFF;
                tok.bytes[4] = l[7:0];
                tok.bytes[5] = l[15:8];
            end
            else if (l >= 17'hF)
            begin
                tok.nbytes   = 3'd4;
                tok.bytes[3] = lx[7:0];
            end
            else
            begin
                tok.nbytes = 3'd3;
            end
        end
    end
endmodule
`default_nettype wire

// ----- sv/lztp_checker.sv -----
`default_nettype none
module lztp_checker
    import lztp_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      out_valid,
    input wire logic      out_stall,
    input wire out_word_t out_data
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output word changed while stalled");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.kind == KIND_BYTE || out_data.kind == KIND_COUNT ||
                       out_data.kind == KIND_ERROR))
        else $error("bad result kind");

    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.chunk_done |-> out_data.kind == KIND_BYTE)
        else $error("chunk_done on a non-byte word");

    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind != KIND_BYTE |-> out_data.last)
        else $error("count or error word not marked last");
endmodule

bind lz77_token_packer_with_histogram lztp_checker u_lztp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
`default_nettype wire

// ----- sim/lz77_token_packer_with_histogram_test.sv -----
`default_nettype none
module lz77_token_packer_with_histogram_test;
    import lztp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;
    localparam int DRAIN_GAP   = 20;   // covers the quiet cycles after a no-op word
    localparam int IN_W        = $bits(in_word_t);

    typedef struct {
        in_word_t  w;
        bit        typed;   // expected word typed in by hand
        out_word_t e;
    } stim_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [16:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_word_t    in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_word_t   out_data;

    lz77_token_packer_with_histogram dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Packer shadow: configuration and chunk state kept at the
    // block's widths, updated as each input word is accepted.
    // ---------------------------------------------------------------
    logic [16:0] sh_chunk_len = 17'd65536;
    logic        sh_final     = 1'b1;
    logic [31:0] sh_mask;
    int          sh_slot;
    int          sh_left;      // 0 means no chunk open
    logic [16:0] sh_waddr;
    logic [16:0] sh_maddr;
    int          sh_hist [SYMBOL_BINS];

    out_word_t   expected_words [$];
    stim_t       pending_words [$];
    int          mismatches = 0;
    int          cycles = 0;

    function automatic void hist_bump(int bin);
        if (sh_hist[bin % SYMBOL_BINS] < int'(COUNT_MAX))
            sh_hist[bin % SYMBOL_BINS]++;
    endfunction

    function automatic out_word_t buf_word(logic [7:0] v, logic [16:0] a);
        out_word_t r;
        r = '0;
        r.kind = KIND_BYTE;
        r.byte_value = v;
        r.byte_address = a;
        return r;
    endfunction

    function automatic void emit_byte(ref out_word_t run[$], input logic [7:0] v);
        run.push_back(buf_word(v, sh_waddr));
        sh_waddr = sh_waddr + 17'd1;
    endfunction

    // the four mask bytes go to a reserved slot, little-endian
    function automatic void emit_mask(ref out_word_t run[$], input logic [31:0] m,
                                      input logic [16:0] a);
        for (int k = 0; k < 4; k++)
            run.push_back(buf_word(m[8*k +: 8], a + 17'(k)));
    endfunction

    // Works out the run of words one accepted input word causes.
    function automatic void pack_token(input in_word_t w, ref out_word_t run[$]);
        int          avail;
        int          len;
        int          l;
        int          bits;
        int          t;
        logic [7:0]  sym;
        logic [15:0] off;
        bit          done;
        out_word_t   r;

        run.delete();
        done = 0;
        if (w.action == ACT_READ)
        begin
            r = '0;
            r.kind = KIND_COUNT;
            r.bin_count = 17'(sh_hist[w.bin_index]);
            run.push_back(r);
        end
        else if (w.action == ACT_LITERAL || w.action == ACT_MATCH)
        begin
            if (sh_left != 0)
                avail = sh_left;
            else if (sh_chunk_len == 0)
                avail = 1;
            else if (sh_chunk_len > 17'd65536)
                avail = 65536;
            else
                avail = sh_chunk_len;

            if (w.action == ACT_MATCH && (w.match_length < 3 || avail < 3))
            begin
                r = '0;
                r.kind = KIND_ERROR;
                run.push_back(r);
            end
            else
            begin
                if (sh_left == 0)
                begin
                    // chunk start
                    sh_left = avail;
                    foreach (sh_hist[i])
                        sh_hist[i] = 0;
                    sh_mask = '0;
                    sh_slot = 0;
                    sh_maddr = '0;
                    sh_waddr = 17'd4;
                end
                if (w.action == ACT_LITERAL)
                begin
                    emit_byte(run, w.literal_byte);
                    hist_bump(w.literal_byte);
                    sh_left--;
                end
                else
                begin
                    len = (w.match_length < sh_left) ? int'(w.match_length) : sh_left;
                    sh_left -= len;
                    l = len - 3;
                    t = w.match_offset | 1;
                    bits = 0;
                    while (t > 1)
                    begin
                        t = t >> 1;
                        bits++;
                    end
                    sym = 8'((bits << 4) | ((l < 15) ? l : 15));
                    hist_bump(256 | sym);
                    off = w.match_offset ^ 16'(1 << bits);
                    emit_byte(run, sym);
                    emit_byte(run, off[7:0]);
                    emit_byte(run, off[15:8]);
                    // clamping keeps l below 0x10000, so the 16-bit long escape holds it
                    if (l >= 270)
                    begin
                        emit_byte(run, 8'hFF);
                        emit_byte(run, 8'(l));
                        emit_byte(run, 8'(l >> 8));
                    end
                    else if (l >= 15)
                        emit_byte(run, 8'(l - 15));
                    sh_mask[sh_slot % 32] = 1'b1;
                end
                sh_slot++;
                if (sh_slot >= GROUP_TOKENS)
                begin
                    emit_mask(run, sh_mask, sh_maddr);
                    if (sh_left > 0)
                    begin
                        sh_maddr = sh_waddr;
                        sh_waddr = sh_waddr + 17'd4;
                        sh_mask = '0;
                        sh_slot = 0;
                    end
                end
                if (sh_left == 0)
                begin
                    done = 1;
                    if (sh_slot < GROUP_TOKENS)
                    begin
                        if (sh_final)
                            sh_mask[sh_slot % 32] = 1'b1;
                        emit_mask(run, sh_mask, sh_maddr);
                    end
                    else if (sh_final)
                    begin
                        // full group at the end: fresh mask holding only end-of-stream
                        emit_mask(run, 32'd1, sh_waddr);
                        sh_waddr = sh_waddr + 17'd4;
                    end
                    if (sh_final)
                    begin
                        emit_byte(run, 8'h00);
                        emit_byte(run, 8'h00);
                        emit_byte(run, 8'h00);
                        hist_bump(EOS_BIN);
                    end
                end
            end
        end
        foreach (run[k])
        begin
            run[k].chunk_done = done;
            run[k].buffer_length = done ? sh_waddr : 17'd0;
            run[k].last = (k == run.size() - 1);
        end
    endfunction

    // ---------------------------------------------------------------
    // Sender: bursts of random length, random gaps between them.
    // A word is only replaced once taken, so a stalled word holds.
    // ---------------------------------------------------------------
    stim_t cur_word;
    int    burst_left = 4;
    int    gap_left = 0;

    always @(posedge clk)
    begin
        out_word_t run [$];
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                pack_token(cur_word.w, run);
                if (cur_word.typed)
                    expected_words.push_back(cur_word.e);
                else
                    foreach (run[k])
                        expected_words.push_back(run[k]);
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 16);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            if (!(in_valid && in_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    cur_word = pending_words.pop_front();
                    in_data <= cur_word.w;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Receiver: stall pattern steps through four modes in turn -
    // free running, light random, heavy random, alternate cycles.
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        out_word_t want;
        cycles <= cycles + 1;
        if (out_valid && !out_stall)
        begin
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected word %p", out_data);
            end
            else
            begin
                want = expected_words.pop_front();
                if (out_data !== want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("word mismatch: expected %p, got %p", want, out_data);
                end
            end
        end
        case ((cycles / 64) % 4)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= cycles[0];
        endcase
    end

    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic in_word_t token(logic [1:0] act, logic [7:0] lit,
                                       logic [16:0] len, logic [15:0] off,
                                       logic [8:0] bin);
        in_word_t w;
        w.action = act;
        w.literal_byte = lit;
        w.match_length = len;
        w.match_offset = off;
        w.bin_index = bin;
        return w;
    endfunction

    function automatic out_word_t lone_word(logic [1:0] k);
        out_word_t r;
        r = '0;
        r.kind = k;
        r.last = 1'b1;
        return r;
    endfunction

    // Random word: mostly well-formed tokens, some reads, errors and no-ops.
    function automatic in_word_t random_token();
        in_word_t w;
        int       pick;
        w = in_word_t'(IN_W'({$urandom, $urandom}));
        pick = $urandom_range(0, 99);
        if (pick < 50)
            w.action = ACT_LITERAL;
        else if (pick < 82)
            w.action = ACT_MATCH;
        else if (pick < 95)
            w.action = ACT_READ;
        else
            w.action = ACT_NONE;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            w.match_length = 17'($urandom_range(3, 20));
        else if (pick < 70)
            w.match_length = 17'($urandom_range(0, 2));
        else if (pick < 90)
            w.match_length = 17'($urandom_range(3, 600));
        // else: full 17-bit random length
        w.match_offset = w.match_offset & 16'((32'd1 << $urandom_range(0, 16)) - 1);
        if ($urandom_range(0, 1) == 0)
            w.bin_index[8] = 1'b1;  // favour the match and end-of-stream bins
        return w;
    endfunction

    task automatic write_reg(logic idx, logic [16:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        if (idx == CFG_CHUNK_LENGTH)
            sh_chunk_len = v;
        else
            sh_final = v[0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_words.size() > 0 || in_valid || expected_words.size() > 0)
            @(posedge clk);
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    task automatic queue_word(in_word_t w);
        stim_t s;
        s.w = w;
        s.typed = 0;
        s.e = '0;
        pending_words.push_back(s);
    endtask

    // chunk length / final flag for each random phase
    int unsigned phase_len [10] = '{64, 1, 0, 131071, 200, 100, 3, 2, 65536, 40};
    bit          phase_fin [10] = '{0, 1, 0, 1, 0, 1, 1, 0, 1, 1};

    initial
    begin
        stim_t dir_table [$];
        stim_t s;

        foreach (sh_hist[i])
            sh_hist[i] = 0;
        sh_mask = '0;
        sh_slot = 0;
        sh_left = 0;
        sh_waddr = '0;
        sh_maddr = '0;

        // Directed part, reset settings (65536, final). Hand-typed rows
        // are the ones that are plain: fresh histogram and error words.
        s = '{w: token(ACT_READ, 8'h00, 17'd0, 16'h0, 9'd0), typed: 1,
              e: lone_word(KIND_COUNT)};
        dir_table.push_back(s);
        s.w = token(ACT_READ, 8'hFF, 17'h1FFFF, 16'hFFFF, 9'd511);
        dir_table.push_back(s);
        s = '{w: token(ACT_MATCH, 8'h00, 17'd2, 16'h0, 9'd0), typed: 1,
              e: lone_word(KIND_ERROR)};
        dir_table.push_back(s);
        s.w = token(ACT_MATCH, 8'hFF, 17'd0, 16'hFFFF, 9'd511);
        dir_table.push_back(s);
        s.typed = 0;
        s.e = '0;
        s.w = token(ACT_NONE, 8'hAA, 17'd5, 16'h5, 9'd3);           // ignored
        dir_table.push_back(s);
        s.w = token(ACT_LITERAL, 8'h00, 17'd0, 16'h0, 9'd0);
        dir_table.push_back(s);
        s.w = token(ACT_LITERAL, 8'hFF, 17'h1FFFF, 16'hFFFF, 9'd511);
        dir_table.push_back(s);
        s.w = token(ACT_MATCH, 8'h00, 17'd3, 16'h0000, 9'd0);       // shortest
        dir_table.push_back(s);
        s.w = token(ACT_MATCH, 8'h00, 17'd17, 16'hFFFF, 9'd0);      // nibble 14
        dir_table.push_back(s);
        s.w = token(ACT_MATCH, 8'h00, 17'd18, 16'h0001, 9'd0);      // one extra byte
        dir_table.push_back(s);
        s.w = token(ACT_MATCH, 8'h00, 17'd272, 16'h8000, 9'd0);     // last single byte
        dir_table.push_back(s);
        s.w = token(ACT_MATCH, 8'h00, 17'd273, 16'h0100, 9'd0);     // 0xFF escape
        dir_table.push_back(s);
        s.w = token(ACT_MATCH, 8'h00, 17'd65536, 16'h7FFF, 9'd0);   // clamped, ends chunk
        dir_table.push_back(s);
        s.w = token(ACT_READ, 8'h00, 17'd0, 16'h0, 9'd255);
        dir_table.push_back(s);
        s.w = token(ACT_READ, 8'h00, 17'd0, 16'h0, EOS_BIN);
        dir_table.push_back(s);
        s.w = token(ACT_MATCH, 8'h00, 17'h1FFFF, 16'h1234, 9'd0);   // opens and ends a chunk
        dir_table.push_back(s);
        s.w = token(ACT_READ, 8'h00, 17'd0, 16'h0, 9'h1FF);
        dir_table.push_back(s);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_table[i])
            pending_words.push_back(dir_table[i]);
        drain();

        // exactly one full group ending the chunk: the fresh-mask case
        write_reg(CFG_CHUNK_LENGTH, 17'd32);
        write_reg(CFG_FINAL_CHUNK, 17'd1);
        for (int i = 0; i < 32; i++)
            queue_word(token(ACT_LITERAL, 8'($urandom), 17'($urandom), 16'($urandom),
                             9'($urandom)));
        queue_word(token(ACT_READ, 8'h00, 17'd0, 16'h0, EOS_BIN));
        drain();

        // random phases; the long chunks get a closing match to end them
        foreach (phase_len[p])
        begin
            write_reg(CFG_CHUNK_LENGTH, 17'(phase_len[p]));
            write_reg(CFG_FINAL_CHUNK, 17'(phase_fin[p]));
            for (int i = 0; i < 16; i++)
                queue_word(random_token());
            if (phase_len[p] >= 65536)
                queue_word(token(ACT_MATCH, 8'h00, 17'd65536, 16'($urandom), 9'd0));
            drain();
        end

        if (mismatches == 0 && expected_words.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire

// ----- files.f -----
sv/lztp_pkg.sv
sv/lztp_ram.sv
sv/lztp_hist.sv
sv/lztp_enc.sv
sv/lz77_token_packer_with_histogram.sv
sv/lztp_checker.sv
sim/lz77_token_packer_with_histogram_test.sv
